FILE: hw/rtl/bfr_pkg.sv
// Shared types and constants for the blink and fade ramp generator.
package bfr_pkg;

    localparam int TICK_W    = 16;
    localparam int CLK_W     = 32;
    localparam int REG_W     = 31;
    localparam int OPAC_W    = 17;
    localparam int FRAC_W    = 16;
    localparam int CFG_IDX_W = 3;

    localparam logic [OPAC_W-1:0] FULL_OPACITY = OPAC_W'(1) << FRAC_W;
    localparam logic [OPAC_W-1:0] ZERO_OPACITY = '0;

    localparam logic [CFG_IDX_W-1:0] CFG_BLINK_PERIOD  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_BLINK_ON_TIME = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_RAMP_REPEAT   = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_RAMP_PERIOD   = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] CFG_RAMP_DOWN     = CFG_IDX_W'(4);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADD,
        ST_WRAP,
        ST_EVAL,
        ST_DIV,
        ST_DONE
    } state_t;

endpackage

FILE: hw/rtl/bfr_div.sv
// Serial restoring divider producing the ramp fraction one quotient bit per cycle.
module bfr_div
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [bfr_pkg::REG_W-1:0]  numer,
    input  logic [bfr_pkg::REG_W-1:0]  denom,
    output logic                       done,
    output logic [bfr_pkg::FRAC_W-1:0] quotient
);

    localparam int CNT_W = $clog2(bfr_pkg::FRAC_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(bfr_pkg::FRAC_W - 1);

    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic [bfr_pkg::REG_W-1:0]  rem_reg, rem_next;
    logic [bfr_pkg::REG_W-1:0]  dsr_reg, dsr_next;
    logic [bfr_pkg::FRAC_W-1:0] quo_reg, quo_next;
    logic [bfr_pkg::REG_W:0]    shifted;
    logic                       fits;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        quo_reg <= quo_next;
    end

    always_comb
    begin
        shifted   = {rem_reg, 1'b0};
        fits      = (shifted >= {1'b0, dsr_reg});
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = numer;
            dsr_next  = denom;
            quo_next  = '0;
        end
        else if (busy_reg)
        begin
            // shift the remainder left one bit per step, subtract the divisor if it fits, shift in the quotient bit
            if (fits)
                rem_next = bfr_pkg::REG_W'(shifted - {1'b0, dsr_reg});
            else
                rem_next = bfr_pkg::REG_W'(shifted);
            quo_next = {quo_reg[bfr_pkg::FRAC_W-2:0], fits};
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

FILE: hw/rtl/blink_and_fade_ramp_generator.sv
// Top level of the blink and fade ramp generator.
// Each request carries the microseconds elapsed since the previous update and
// yields one result: the blink state, the ramp opacity (65536 is fully
// opaque) and a flag that the opacity was computed on this update. A request
// passes through the add, wrap and evaluate states to the done state, and
// through the divide state as well when the ramp is enabled and the ramp
// clock lies inside the ramp period, where the 16-step serial divider forms
// the opacity fraction. The next request can be accepted in the same cycle
// that the result appears. in_stall stays high while a request is in
// progress; a finished result sits in the output register until taken, and
// the next request is accepted meanwhile.
// Configuration is written through cfg_valid/cfg_ready while idle.
module blink_and_fade_ramp_generator
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [bfr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bfr_pkg::REG_W-1:0]     cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [bfr_pkg::TICK_W-1:0]    elapsed_ticks,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          blink_on,
    output logic [bfr_pkg::OPAC_W-1:0]    opacity,
    output logic                          opacity_valid
);

    bfr_pkg::state_t state_reg, state_next;

    logic [bfr_pkg::REG_W-1:0]  blink_period_reg, blink_period_next;
    logic [bfr_pkg::REG_W-1:0]  blink_on_time_reg, blink_on_time_next;
    logic [bfr_pkg::REG_W-1:0]  ramp_repeat_reg, ramp_repeat_next;
    logic [bfr_pkg::REG_W-1:0]  ramp_period_reg, ramp_period_next;
    logic                       ramp_down_reg, ramp_down_next;

    logic [bfr_pkg::CLK_W-1:0]  blink_clock_reg, blink_clock_next;
    logic                       blink_state_reg, blink_state_next;
    logic [bfr_pkg::CLK_W-1:0]  ramp_clock_reg, ramp_clock_next;
    logic [bfr_pkg::OPAC_W-1:0] last_opacity_reg, last_opacity_next;

    logic [bfr_pkg::TICK_W-1:0] tick_reg, tick_next;
    logic [bfr_pkg::CLK_W-1:0]  blink_sum_reg, blink_sum_next;
    logic [bfr_pkg::CLK_W-1:0]  ramp_sum_reg, ramp_sum_next;
    logic                       in_ramp_reg, in_ramp_next;
    logic [bfr_pkg::FRAC_W-1:0] frac_reg, frac_next;

    logic                       out_valid_reg, out_valid_next;
    logic                       blink_on_reg, blink_on_next;
    logic [bfr_pkg::OPAC_W-1:0] opacity_reg, opacity_next;
    logic                       opacity_valid_reg, opacity_valid_next;

    logic                       blink_en;
    logic                       ramp_en;
    logic                       in_ramp_eval;
    logic                       div_start;
    logic                       div_done;
    logic [bfr_pkg::FRAC_W-1:0] div_quotient;
    logic [bfr_pkg::OPAC_W-1:0] opac_calc;
    logic                       cfg_write;
    logic                       in_accept;
    logic                       out_free;

    bfr_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .numer    (ramp_clock_reg[bfr_pkg::REG_W-1:0]),
        .denom    (ramp_period_reg),
        .done     (div_done),
        .quotient (div_quotient)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= bfr_pkg::ST_IDLE;
            blink_period_reg  <= '0;
            blink_on_time_reg <= '0;
            ramp_repeat_reg   <= '0;
            ramp_period_reg   <= '0;
            ramp_down_reg     <= 1'b0;
            blink_clock_reg   <= '0;
            blink_state_reg   <= 1'b1;
            ramp_clock_reg    <= '0;
            last_opacity_reg  <= bfr_pkg::FULL_OPACITY;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            blink_period_reg  <= blink_period_next;
            blink_on_time_reg <= blink_on_time_next;
            ramp_repeat_reg   <= ramp_repeat_next;
            ramp_period_reg   <= ramp_period_next;
            ramp_down_reg     <= ramp_down_next;
            blink_clock_reg   <= blink_clock_next;
            blink_state_reg   <= blink_state_next;
            ramp_clock_reg    <= ramp_clock_next;
            last_opacity_reg  <= last_opacity_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tick_reg          <= tick_next;
        blink_sum_reg     <= blink_sum_next;
        ramp_sum_reg      <= ramp_sum_next;
        in_ramp_reg       <= in_ramp_next;
        frac_reg          <= frac_next;
        blink_on_reg      <= blink_on_next;
        opacity_reg       <= opacity_next;
        opacity_valid_reg <= opacity_valid_next;
    end

    assign blink_en  = (blink_period_reg != '0);
    assign ramp_en   = (ramp_repeat_reg != '0);
    assign cfg_ready = (state_reg == bfr_pkg::ST_IDLE);
    assign cfg_write = cfg_valid && cfg_ready;
    assign in_stall  = (state_reg != bfr_pkg::ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    assign in_ramp_eval = (ramp_period_reg != '0)
                       && (ramp_clock_reg < {1'b0, ramp_period_reg});
    assign div_start    = (state_reg == bfr_pkg::ST_EVAL) && ramp_en && in_ramp_eval;

    always_comb
    begin
        if (!ramp_down_reg)
            opac_calc = in_ramp_reg ? {1'b0, frac_reg} : bfr_pkg::FULL_OPACITY;
        else
            opac_calc = in_ramp_reg ? (bfr_pkg::FULL_OPACITY - {1'b0, frac_reg})
                                    : bfr_pkg::ZERO_OPACITY;
    end

    always_comb
    begin
        state_next         = state_reg;
        blink_period_next  = blink_period_reg;
        blink_on_time_next = blink_on_time_reg;
        ramp_repeat_next   = ramp_repeat_reg;
        ramp_period_next   = ramp_period_reg;
        ramp_down_next     = ramp_down_reg;
        blink_clock_next   = blink_clock_reg;
        blink_state_next   = blink_state_reg;
        ramp_clock_next    = ramp_clock_reg;
        last_opacity_next  = last_opacity_reg;
        tick_next          = tick_reg;
        blink_sum_next     = blink_sum_reg;
        ramp_sum_next      = ramp_sum_reg;
        in_ramp_next       = in_ramp_reg;
        frac_next          = frac_reg;
        out_valid_next     = out_valid_reg;
        blink_on_next      = blink_on_reg;
        opacity_next       = opacity_reg;
        opacity_valid_next = opacity_valid_reg;

        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        if (cfg_write)
        begin
            case (cfg_index)
                bfr_pkg::CFG_BLINK_PERIOD:  blink_period_next  = cfg_data;
                bfr_pkg::CFG_BLINK_ON_TIME: blink_on_time_next = cfg_data;
                bfr_pkg::CFG_RAMP_REPEAT:   ramp_repeat_next   = cfg_data;
                bfr_pkg::CFG_RAMP_PERIOD:   ramp_period_next   = cfg_data;
                bfr_pkg::CFG_RAMP_DOWN:     ramp_down_next     = cfg_data[0];
                default: ;
            endcase
        end

        case (state_reg)
            bfr_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    tick_next  = elapsed_ticks;
                    state_next = bfr_pkg::ST_ADD;
                end
            end
            bfr_pkg::ST_ADD:
            begin
                // advance both clocks, wrapping modulo 2^32
                blink_sum_next = blink_clock_reg + bfr_pkg::CLK_W'(tick_reg);
                ramp_sum_next  = ramp_clock_reg + bfr_pkg::CLK_W'(tick_reg);
                state_next     = bfr_pkg::ST_WRAP;
            end
            bfr_pkg::ST_WRAP:
            begin
                // subtract at most one period
                if (blink_en)
                begin
                    if (blink_sum_reg > {1'b0, blink_period_reg})
                        blink_clock_next = blink_sum_reg - {1'b0, blink_period_reg};
                    else
                        blink_clock_next = blink_sum_reg;
                end
                if (ramp_en)
                begin
                    if (ramp_sum_reg > {1'b0, ramp_repeat_reg})
                        ramp_clock_next = ramp_sum_reg - {1'b0, ramp_repeat_reg};
                    else
                        ramp_clock_next = ramp_sum_reg;
                end
                state_next = bfr_pkg::ST_EVAL;
            end
            bfr_pkg::ST_EVAL:
            begin
                if (blink_en)
                    blink_state_next = !(blink_clock_reg > {1'b0, blink_on_time_reg});
                in_ramp_next = in_ramp_eval;
                frac_next    = '0;
                if (div_start)
                    state_next = bfr_pkg::ST_DIV;
                else
                    state_next = bfr_pkg::ST_DONE;
            end
            bfr_pkg::ST_DIV:
            begin
                if (div_done)
                begin
                    frac_next  = div_quotient;
                    state_next = bfr_pkg::ST_DONE;
                end
            end
            bfr_pkg::ST_DONE:
            begin
                // hold until the output register is free
                if (out_free)
                begin
                    out_valid_next     = 1'b1;
                    blink_on_next      = blink_state_reg;
                    opacity_valid_next = ramp_en;
                    if (ramp_en)
                    begin
                        last_opacity_next = opac_calc;
                        opacity_next      = opac_calc;
                    end
                    else
                        opacity_next = last_opacity_reg;
                    state_next = bfr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bfr_pkg::ST_IDLE;
            end
        endcase
    end

    assign out_valid     = out_valid_reg;
    assign blink_on      = blink_on_reg;
    assign opacity       = opacity_reg;
    assign opacity_valid = opacity_valid_reg;

endmodule

FILE: hw/rtl/bfr_checker.sv
// Port-level assertions for the blink and fade ramp generator, bound to the top level.
module bfr_checker
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_stall,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic                          blink_on,
    input logic [bfr_pkg::OPAC_W-1:0]    opacity,
    input logic                          opacity_valid
);

    a_busy_after_request: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("request accepted but block did not go busy");

    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared without a request in progress");

    a_opacity_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (opacity <= bfr_pkg::FULL_OPACITY))
        else $error("opacity above full scale");

    a_stalled_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(opacity)
                                      && $stable(blink_on) && $stable(opacity_valid)))
        else $error("stalled result changed");

endmodule

bind blink_and_fade_ramp_generator bfr_checker u_bfr_checker (.*);
